/* sv/ctt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants of the connection timeout timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

  localparam int unsigned MaxSlotsDefault = 64;
  localparam int unsigned CmdW = 2;
  localparam int unsigned SlotW = 6;
  localparam int unsigned TimeoutW = 20;
  localparam int unsigned KindW = 2;
  localparam int unsigned NextW = 21;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ResultCap = 64;
  localparam logic [NextW-1:0] NextMax = 21'd1048575;
  localparam logic [NextW-1:0] NextNone = '1;

  localparam logic [CmdW-1:0] CmdAdd = 2'd0;
  localparam logic [CmdW-1:0] CmdDel = 2'd1;
  localparam logic [CmdW-1:0] CmdTick = 2'd2;

  localparam logic [KindW-1:0] KindAck = 2'd0;
  localparam logic [KindW-1:0] KindFired = 2'd1;
  localparam logic [KindW-1:0] KindEmpty = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]     cmd;
    logic [SlotW-1:0]    slot;
    logic [TimeoutW-1:0] timeout;
  } cmd_t;

endpackage

/* sv/ctt_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_front
// Accepts command beats into a two-entry queue toward the scan engine.
// ----------------------------------------------------------------------------
module ctt_front
  import ctt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  cmd_t             cmd_i,
  output logic             q_valid_o,
  input  logic             q_pop_i,
  output cmd_t             q_data_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign stall_o   = (cnt_q == 2'd2);
  assign push      = valid_i && !stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 && !push) |=> cnt_q == 2'd0)
    else $error("queue count changed without push");

endmodule

/* sv/ctt_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_back
// Scan engine: applies commands, scans the slot table for the earliest
// expiry, and emits result beats through an output register.
// ----------------------------------------------------------------------------
module ctt_back
  import ctt_pkg::*;
#(
  parameter int unsigned MaxSlots = MaxSlotsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_pop_o,
  input  cmd_t             q_data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [KindW-1:0] kind_o,
  output logic [SlotW-1:0] fired_slot_o,
  output logic signed [NextW-1:0] next_expire_o,
  output logic             last_o
);

  localparam int unsigned IdxW = (MaxSlots > 1) ? $clog2(MaxSlots) : 1;
  localparam int unsigned CntW = $clog2(MaxSlots + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(MaxSlots - 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StRd   = 3'd2;
  localparam logic [2:0] StEval = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [TimeW-1:0] exp_mem [MaxSlots];
  logic [MaxSlots-1:0] armed_q;
  logic [TimeW-1:0] now_q;
  logic [2:0]       st_q;
  cmd_t             cur_q;
  logic [CntW-1:0]  idx_q;
  logic [IdxW-1:0]  rd_idx_q;
  logic             rd_vld_q;
  logic [TimeW-1:0] rd_data_q;
  logic             best_vld_q;
  logic [IdxW-1:0]  best_idx_q;
  logic signed [TimeW-1:0] best_left_q;
  logic [6:0]       nfired_q;
  logic [SlotW-1:0] pend_slot_q;
  logic             ovalid_q;
  logic [KindW-1:0] kind_q;
  logic [SlotW-1:0] slot_q;
  logic [NextW-1:0] next_q;
  logic             last_q;

  logic signed [TimeW-1:0] left;
  logic             in_range;
  logic [IdxW-1:0]  cur_idx;
  logic [NextW-1:0] next_val;
  logic             fire;
  logic             is_tick;
  logic             out_free;
  logic             emit;

  assign left     = signed'(rd_data_q - now_q);
  assign in_range = ({{(32-SlotW){1'b0}}, cur_q.slot} < 32'(MaxSlots));
  assign cur_idx  = IdxW'(cur_q.slot);
  assign fire     = best_vld_q && (best_left_q <= 0) && (nfired_q < 7'(ResultCap));
  assign is_tick  = (cur_q.cmd == CmdTick);
  assign out_free = !ovalid_q || !stall_i;
  // The first expiry of a tick is only reported after its rescan.
  assign emit     = (st_q == StOut) && out_free &&
                    !(is_tick && nfired_q == '0 && fire);

  always_comb begin
    if (!best_vld_q) next_val = NextNone;
    else if (best_left_q < 0) next_val = '0;
    else if (best_left_q > signed'(32'(NextMax))) next_val = NextMax;
    else next_val = best_left_q[NextW-1:0];
  end

  assign q_pop_o       = (st_q == StIdle) && q_valid_i && !ovalid_q;
  assign valid_o       = ovalid_q;
  assign kind_o        = kind_q;
  assign fired_slot_o  = slot_q;
  assign next_expire_o = signed'(next_q);
  assign last_o        = last_q;

  always_ff @(posedge clk_i) begin
    if (st_q == StScan && cur_q.cmd == CmdAdd && idx_q == '0 && in_range) begin
      exp_mem[cur_idx] <= now_q + {{(TimeW-TimeoutW){1'b0}}, cur_q.timeout};
    end
    rd_data_q <= exp_mem[idx_q[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= '0;
      now_q      <= '0;
      st_q       <= StIdle;
      cur_q      <= '0;
      idx_q      <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      best_vld_q <= 1'b0;
      best_idx_q <= '0;
      best_left_q <= '0;
      nfired_q   <= '0;
      pend_slot_q <= '0;
      ovalid_q   <= 1'b0;
      kind_q     <= '0;
      slot_q     <= '0;
      next_q     <= '0;
      last_q     <= 1'b0;
    end else begin
      if (emit) ovalid_q <= 1'b1;
      else if (!stall_i) ovalid_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (q_pop_o) begin
            cur_q    <= q_data_i;
            idx_q    <= '0;
            nfired_q <= '0;
            st_q     <= StScan;
            if (q_data_i.cmd == CmdTick) now_q <= now_q + 1'b1;
          end
        end
        StScan: begin
          // First pass cycle applies add or delete before the sweep.
          if (idx_q == '0 && in_range) begin
            if (cur_q.cmd == CmdAdd) armed_q[cur_idx] <= 1'b1;
            else if (cur_q.cmd == CmdDel) armed_q[cur_idx] <= 1'b0;
          end
          best_vld_q <= 1'b0;
          rd_idx_q   <= '0;
          rd_vld_q   <= 1'b0;
          idx_q      <= '0;
          st_q       <= StRd;
        end
        StRd: begin
          // One slot read per StRd/StEval pair; data lands in rd_data_q next cycle.
          rd_idx_q <= idx_q[IdxW-1:0];
          rd_vld_q <= armed_q[idx_q[IdxW-1:0]];
          st_q     <= StEval;
        end
        StEval: begin
          if (rd_vld_q && (!best_vld_q || left < best_left_q)) begin
            best_vld_q  <= 1'b1;
            best_idx_q  <= rd_idx_q;
            best_left_q <= left;
          end
          if (idx_q == LastIdx) st_q <= StOut;
          else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= StRd;
          end
        end
        default: begin
          if (out_free) begin
            if (emit) begin
              next_q <= next_val;
              if (is_tick && nfired_q != '0) begin
                // The slot fired before this sweep; last once nothing else is due or the fire cap is reached.
                kind_q <= KindFired;
                slot_q <= pend_slot_q;
                last_q <= !fire;
              end else if (is_tick) begin
                kind_q <= KindEmpty;
                slot_q <= '0;
                last_q <= 1'b1;
              end else begin
                kind_q <= KindAck;
                slot_q <= '0;
                last_q <= 1'b1;
              end
            end
            if (is_tick && fire) begin
              armed_q[best_idx_q] <= 1'b0;
              pend_slot_q <= SlotW'(best_idx_q);
              nfired_q    <= nfired_q + 1'b1;
              st_q        <= StScan;
              idx_q       <= CntW'(1);
            end else begin
              st_q <= StIdle;
            end
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> valid_o)
    else $error("result beat dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    nfired_q <= 7'(ResultCap))
    else $error("fire count beyond cap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> st_q == StIdle)
    else $error("pop while busy");

endmodule

/* sv/connection_timeout_timer_table_unit.sv */
`timescale 1ns / 1ps
// The back end handles one command at a time and pops no new one until its
// results are out; a tick that fires k slots takes (k+1) table sweeps, each
// reading one slot per StRd/StEval pair.
// Reset: asynchronous, clears the clock, armed marks, queue and output.
// The expiry memory is not cleared; armed marks gate every read.
// ----------------------------------------------------------------------------
// connection_timeout_timer_table_unit
// Timer table: a command queue front and a scanning back end.
// ----------------------------------------------------------------------------
module connection_timeout_timer_table_unit
  import ctt_pkg::*;
#(
  parameter int unsigned MaxSlots = MaxSlotsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic [SlotW-1:0]        conn_slot_i,
  input  logic [TimeoutW-1:0]     timeout_ms_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [KindW-1:0]        kind_o,
  output logic [SlotW-1:0]        fired_slot_o,
  output logic signed [NextW-1:0] next_expire_o,
  output logic                    last_o
);

  cmd_t in_beat, q_data;
  logic q_valid, q_pop;

  assign in_beat = '{cmd: cmd_i, slot: conn_slot_i, timeout: timeout_ms_i};

  ctt_front u_front (
    .clk_i, .rst_ni, .valid_i, .stall_o, .cmd_i(in_beat),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_data_o(q_data)
  );

  ctt_back #(.MaxSlots(MaxSlots)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_data_i(q_data),
    .valid_o, .stall_i, .kind_o, .fired_slot_o, .next_expire_o, .last_o
  );

endmodule

/* tb/connection_timeout_timer_table_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// connection_timeout_timer_table_unit_test
// Self-checking bench for the connection timeout timer table.
// Commands are sent as bursts of beats with random gaps, while the result
// side stalls on its own random pattern. A behavioral timer table in the
// bench predicts every result beat, and the checker compares the beats in
// order, field by field.
// ----------------------------------------------------------------------------
module connection_timeout_timer_table_unit_test;
  import ctt_pkg::*;

  localparam int unsigned Slots = MaxSlotsDefault;

  // Stimulus and response signals. Every input starts at a known value.
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    valid_i = 1'b0;
  logic                    stall_o;
  logic [CmdW-1:0]         cmd_i = CmdAdd;
  logic [SlotW-1:0]        conn_slot_i = '0;
  logic [TimeoutW-1:0]     timeout_ms_i = '0;
  logic                    valid_o;
  logic                    stall_i = 1'b0;
  logic [KindW-1:0]        kind_o;
  logic [SlotW-1:0]        fired_slot_o;
  logic signed [NextW-1:0] next_expire_o;
  logic                    last_o;

  // One predicted result beat.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [SlotW-1:0] slot;
    logic [NextW-1:0] next;
    logic             last;
  } timer_event_t;

  // Mirror of the timer table state.
  logic [TimeW-1:0] model_now;
  logic             model_armed [Slots];
  logic [TimeW-1:0] model_expiry [Slots];

  timer_event_t pending_events[$];
  int unsigned  error_count = 0;
  int unsigned  events_seen = 0;
  int unsigned  fires_seen = 0;
  int unsigned  beats_sent = 0;
  int unsigned  burst_left = 0;
  int unsigned  stall_percent = 0;

  connection_timeout_timer_table_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .cmd_i        (cmd_i),
    .conn_slot_i  (conn_slot_i),
    .timeout_ms_i (timeout_ms_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .kind_o       (kind_o),
    .fired_slot_o (fired_slot_o),
    .next_expire_o(next_expire_o),
    .last_o       (last_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard limit on the run, well above the slowest correct run.
  initial begin
    #200ms;
    $display("Timeout at %0t with %0d result beats still pending", $time,
             pending_events.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Wrapped signed distance from the current time to an expiry.
  function automatic longint time_to_expiry(input logic [TimeW-1:0] expiry);
    logic [TimeW-1:0] diff;
    diff = expiry - model_now;
    return longint'($signed(diff));
  endfunction

  // Earliest armed slot, lowest index on ties, or -1 when nothing is armed.
  function automatic int earliest_armed_slot();
    int     best;
    longint best_left;
    longint left;
    best = -1;
    best_left = 0;
    for (int i = 0; i < Slots; i++) begin
      if (model_armed[i]) begin
        left = time_to_expiry(model_expiry[i]);
        if (best < 0 || left < best_left) begin
          best = i;
          best_left = left;
        end
      end
    end
    return best;
  endfunction

  // The next_expire field as seen from the present table contents.
  function automatic logic [NextW-1:0] time_to_next_expiry();
    int     s;
    longint left;
    s = earliest_armed_slot();
    if (s < 0) return NextNone;
    left = time_to_expiry(model_expiry[s]);
    if (left < 0) left = 0;
    if (left > longint'(NextMax)) left = longint'(NextMax);
    return NextW'(left);
  endfunction

  function automatic void queue_timer_event(input logic [KindW-1:0] kind,
                                            input logic [SlotW-1:0] slot,
                                            input logic last);
    timer_event_t ev;
    ev.kind = kind;
    ev.slot = slot;
    ev.next = time_to_next_expiry();
    ev.last = last;
    pending_events.push_back(ev);
  endfunction

  // Applies one accepted command to the mirror and queues its result beats.
  function automatic void apply_command(input logic [CmdW-1:0] cmd,
                                        input logic [SlotW-1:0] slot,
                                        input logic [TimeoutW-1:0] timeout);
    int n;
    int s;
    n = 0;
    if (cmd == CmdTick) begin
      model_now = model_now + 1;
      while (n < ResultCap) begin
        s = earliest_armed_slot();
        if (s < 0) break;
        if (time_to_expiry(model_expiry[s]) > 0) break;
        model_armed[s] = 1'b0;
        queue_timer_event(KindFired, SlotW'(s), 1'b0);
        n++;
      end
      if (n == 0) begin
        queue_timer_event(KindEmpty, '0, 1'b1);
      end else begin
        // Only the final fired beat of the tick carries the last flag.
        pending_events[pending_events.size() - 1].last = 1'b1;
      end
    end else begin
      if (cmd == CmdAdd) begin
        model_expiry[slot] = model_now + TimeW'(timeout);
        model_armed[slot] = 1'b1;
      end else if (cmd == CmdDel) begin
        model_armed[slot] = 1'b0;
      end
      // The unused command code falls through here and is only acknowledged.
      queue_timer_event(KindAck, '0, 1'b1);
    end
  endfunction

  // Sends one command beat. Must be called at a rising edge; it returns at
  // the edge where the beat was accepted, so a following beat of the same
  // burst keeps valid high with no gap between the beats.
  task automatic send_command(input logic [CmdW-1:0] cmd,
                              input logic [SlotW-1:0] slot,
                              input logic [TimeoutW-1:0] timeout);
    if (burst_left == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      // Mostly short bursts, sometimes a long run with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(1, 4);
    end
    burst_left--;
    valid_i      <= 1'b1;
    cmd_i        <= cmd;
    conn_slot_i  <= slot;
    timeout_ms_i <= timeout;
    do @(posedge clk_i); while (stall_o);
    apply_command(cmd, slot, timeout);
    beats_sent++;
  endtask

  // Drops valid and waits until every predicted beat has come back.
  task automatic drain_results();
    valid_i <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Receiver stall pattern: a per-phase stall rate, redrawn every cycle.
  always @(posedge clk_i) begin
    stall_i <= ($urandom_range(0, 99) < stall_percent);
  end

  // Result checker: each accepted beat against the oldest prediction.
  always @(posedge clk_i) begin
    timer_event_t ev;
    if (rst_ni && valid_o && !stall_i) begin
      events_seen++;
      if (kind_o == KindFired) fires_seen++;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result beat kind %0d slot %0d next %0d", $time,
                 kind_o, fired_slot_o, next_expire_o);
        error_count++;
      end else begin
        ev = pending_events.pop_front();
        if (kind_o !== ev.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, ev.kind, kind_o);
          error_count++;
        end
        if (fired_slot_o !== ev.slot) begin
          $display("%0t: fired_slot expected %0d actual %0d", $time, ev.slot,
                   fired_slot_o);
          error_count++;
        end
        if (next_expire_o !== $signed(ev.next)) begin
          $display("%0t: next_expire expected %0d actual %0d", $time,
                   $signed(ev.next), next_expire_o);
          error_count++;
        end
        if (last_o !== ev.last) begin
          $display("%0t: last expected %0d actual %0d", $time, ev.last, last_o);
          error_count++;
        end
      end
    end
  end

  // Adds, deletes, the unused command and ticks on a quiet table; one tick fires slot 5.
  task automatic test_basic_commands();
    stall_percent = 0;
    send_command(CmdTick, '0, '0);
    send_command(CmdDel, 6'd5, '0);            // delete of a disarmed slot
    send_command(CmdAdd, 6'd5, 20'd3);
    send_command(CmdAdd, 6'd9, 20'd3);         // tie with slot 5
    send_command(CmdAdd, 6'd5, 20'd7);         // re-arm replaces the timer
    send_command(2'd3, 6'h3F, 20'hFFFFF);      // unused command code
    send_command(CmdDel, 6'd9, '0);
    repeat (8) send_command(CmdTick, '0, '0);
    drain_results();
  endtask

  // Zero timeout fires on the next tick; the largest one only gets armed.
  task automatic test_timeout_extremes();
    stall_percent = 30;
    send_command(CmdAdd, 6'd0, 20'd0);
    send_command(CmdAdd, 6'h3F, 20'hFFFFF);
    send_command(CmdTick, '0, '0);
    send_command(CmdTick, '0, '0);
    send_command(CmdDel, 6'h3F, '0);
    send_command(CmdTick, '0, '0);
    drain_results();
  endtask

  // Arms every slot for the same moment, so one tick fires the whole table.
  task automatic test_mass_expiry();
    stall_percent = 50;
    for (int i = Slots - 1; i >= 0; i--) begin
      send_command(CmdAdd, SlotW'(i), 20'd2);
    end
    repeat (3) send_command(CmdTick, '0, '0);
    drain_results();
  endtask

  // Random traffic: mostly short timeouts so slots keep firing, with some
  // full-range timeouts, deletes and stray command codes mixed in.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    logic [TimeoutW-1:0] timeout;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 100 == 0) stall_percent = $urandom_range(0, 3) * 25;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) timeout = TimeoutW'($urandom());
      else timeout = TimeoutW'($urandom_range(0, 12));
      if (pick < 40) send_command(CmdAdd, SlotW'($urandom()), timeout);
      else if (pick < 55) send_command(CmdDel, SlotW'($urandom()), timeout);
      else if (pick < 95) send_command(CmdTick, SlotW'($urandom()), timeout);
      else send_command(2'd3, SlotW'($urandom()), timeout);
    end
    drain_results();
  endtask

  initial begin
    model_now = '0;
    for (int i = 0; i < Slots; i++) begin
      model_armed[i] = 1'b0;
      model_expiry[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_commands();
    test_timeout_extremes();
    test_mass_expiry();
    test_random_traffic(292);

    // Keep the clock running so that any stray beat can still show up.
    repeat (400) @(posedge clk_i);
    if (pending_events.size() != 0) begin
      $display("%0t: %0d predicted result beats never arrived", $time,
               pending_events.size());
      error_count++;
    end
    $display("Sent %0d command beats; checked %0d result beats, %0d of them expiries.",
             beats_sent, events_seen, fires_seen);
    $display("Final clock %0d ms, %0d field mismatches.", model_now, error_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
